### rtl/double_ended_queue_core_assert.svh
// Assertion macros for the double-ended queue core.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define DQ_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define DQ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dq_pkg.sv
// Shared types and constants of the double-ended queue core.
// No dependencies; every other file but the assertion header imports it.
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH_DEF  = 16;
  localparam int DQ_DATA_W     = 32;
  localparam int DQ_MODE_W     = 3;
  localparam int DQ_STATUS_W   = 2;
  localparam int DQ_CMDQ_DEPTH = 2;
  localparam int DQ_CMDQ_PTR_W = $clog2(DQ_CMDQ_DEPTH);

  // Operation codes carried in the mode field
  typedef enum logic [DQ_MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_LIST       = 3'd4
  } mode_t;

  // Result status codes
  typedef enum logic [DQ_STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Back end sequencer states
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  typedef struct packed {
    mode_t                        mode;
    logic signed [DQ_DATA_W-1:0]  value;
  } cmd_t;

  // Command plus its valid flag, between front, queue and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

`default_nettype wire

### rtl/dq_if.sv
// Channel interfaces of the double-ended queue core: item input and result output.
// Depends on dq_pkg for field widths.
`default_nettype none

interface dq_in_if import dq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [DQ_MODE_W-1:0]        mode;
  logic signed [DQ_DATA_W-1:0] item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface dq_out_if import dq_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DQ_DATA_W-1:0] out_value;
  logic [DQ_STATUS_W-1:0]      status;
  logic                        last_of_run;

  modport source (output valid, output out_value, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_value, input status, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

### rtl/double_ended_queue_core.sv
// Double-ended queue core, top level.
// Channels: in_ch carries one operation per beat (mode, item_value); out_ch carries
// result beats (out_value, status, last_of_run), both valid/ready handshakes.
// Modes: push back, push front, pop back, pop front, list. Other mode codes are
// accepted and dropped without a result.
// A push result or an empty status is loaded into the result register when the back
// end takes the command; a popped entry follows its registered slot read. A list
// streams one entry per cycle while the receiver is ready, front to back, with
// last_of_run on the final one; an empty queue gives a single empty beat. The back
// end runs one operation at a time through a single registered slot read port.
// A two-entry command queue sits between decode and execution, so input beats are
// taken while a result waits. When the receiver stalls, the result register holds,
// the back end halts and in_ch.ready drops once the command queue fills.
// Reset (rst_n low, synchronous) empties the queue; slot contents are not cleared.
`default_nettype none
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core import dq_pkg::*; #(
  parameter int DEPTH = DQ_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_req_t          cmdq_wr;
  cmd_req_t          cmdq_rd;
  logic              cmdq_full;
  logic              cmdq_pop;
  logic [CNT_W-1:0]  entry_count;

  // Decode incoming beats
  dq_front u_front (
    .in_ch     (in_ch),
    .cmdq_full (cmdq_full),
    .cmdq_wr   (cmdq_wr)
  );

  // Decouple decode from execution
  dq_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cmdq_wr),
    .full  (cmdq_full),
    .rd    (cmdq_rd),
    .pop   (cmdq_pop)
  );

  // Execute operations on the ring
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmdq_rd),
    .cmd_pop     (cmdq_pop),
    .out_ch      (out_ch),
    .entry_count (entry_count)
  );

  // Internal consistency checks
  `DQ_CHECK_SAME(a_count_bound, 1'b1, entry_count <= CNT_W'(DEPTH), "entry count above depth")
  `DQ_CHECK_SAME(a_cmdq_no_overflow, cmdq_wr.valid, !cmdq_full, "write into full command queue")
  `DQ_CHECK_SAME(a_pop_needs_cmd, cmdq_pop, cmdq_rd.valid, "back end took a missing command")
  `DQ_CHECK_NEXT(a_cmdq_fill, cmdq_wr.valid && !cmdq_rd.valid, cmdq_rd.valid, "command lost")

endmodule

`default_nettype wire

### rtl/dq_front.sv
// Front end: accepts input beats, decodes the mode and drops unused codes.
// Depends on dq_pkg and dq_in_if; feeds dq_cmd_fifo.
`default_nettype none

module dq_front import dq_pkg::*; (
  dq_in_if.sink     in_ch,
  input  logic      cmdq_full,
  output cmd_req_t  cmdq_wr
);

  logic mode_ok;

  // Recognize the five defined operations
  always_comb begin
    mode_ok = (in_ch.mode == MODE_PUSH_BACK)  || (in_ch.mode == MODE_PUSH_FRONT) ||
              (in_ch.mode == MODE_POP_BACK)   || (in_ch.mode == MODE_POP_FRONT)  ||
              (in_ch.mode == MODE_LIST);
  end

  // Accept while the command queue has room; unused codes are swallowed
  assign in_ch.ready         = !cmdq_full;
  assign cmdq_wr.valid       = in_ch.valid && !cmdq_full && mode_ok;
  assign cmdq_wr.cmd.mode    = mode_t'(in_ch.mode);
  assign cmdq_wr.cmd.value   = in_ch.item_value;

endmodule

`default_nettype wire

### rtl/dq_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on dq_pkg.
`default_nettype none

module dq_cmd_fifo import dq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_req_t wr,
  output logic     full,
  output cmd_req_t rd,
  input  logic     pop
);

  localparam logic [DQ_CMDQ_PTR_W-1:0] PTR_LAST = DQ_CMDQ_PTR_W'(DQ_CMDQ_DEPTH - 1);
  localparam int CNT_W = $clog2(DQ_CMDQ_DEPTH + 1);

  cmd_t                     entry_r [DQ_CMDQ_DEPTH];
  logic [DQ_CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [DQ_CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DQ_CMDQ_DEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.cmd   = entry_r[rd_ptr_r];
  assign do_wr   = wr.valid && !full;
  assign do_rd   = pop && rd.valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the command payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr.cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/dq_back.sv
// Back end: ring storage, front index and entry count, list sequencer and result register.
// Depends on dq_pkg and dq_out_if; consumes commands from dq_cmd_fifo.
`default_nettype none

module dq_back import dq_pkg::*; #(
  parameter int DEPTH = DQ_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_req_t                      cmd,
  output logic                          cmd_pop,
  dq_out_if.source                      out_ch,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_X  = (IW+1)'(DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  // Ring slots
  logic signed [DQ_DATA_W-1:0] mem [DEPTH];
  logic signed [DQ_DATA_W-1:0] rd_data_r;

  back_state_t                 state_r, state_nxt;
  logic [IW-1:0]               front_r, front_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               issued_r, issued_nxt;
  logic                        single_r, single_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [DQ_DATA_W-1:0] out_value_r;
  status_t                     out_status_r;
  logic                        out_last_r;

  logic                        wr_en, rd_en, load;
  logic [IW-1:0]               wr_addr, rd_addr;
  logic signed [DQ_DATA_W-1:0] ld_value;
  status_t                     ld_status;
  logic                        ld_last;
  logic                        out_free, is_full, is_empty;
  logic [IW-1:0]               front_inc, front_dec;
  logic [CW-1:0]               count_m1;

  // Wrap an offset from a ring index
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IW-1:0];
  endfunction

  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_full     = (count_r == CNT_FULL);
  assign is_empty    = (count_r == '0);
  assign front_inc   = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign front_dec   = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign count_m1    = count_r - 1'b1;
  assign entry_count = count_r;

  // Next state, slot access and result load
  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    issued_nxt = issued_r;
    single_nxt = single_r;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = front_r;
    rd_en      = 1'b0;
    rd_addr    = front_r;
    load       = 1'b0;
    ld_value   = '0;
    ld_status  = ST_OK;
    ld_last    = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (cmd.valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.cmd.mode)
            MODE_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ring_add(front_r, count_r[IW-1:0]);
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_PUSH_FRONT: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = ring_add(front_r, count_m1[IW-1:0]);
                count_nxt  = count_m1;
                single_nxt = 1'b1;
                state_nxt  = BK_READ;
              end
            end
            MODE_POP_FRONT: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front_r;
                front_nxt  = front_inc;
                count_nxt  = count_m1;
                single_nxt = 1'b1;
                state_nxt  = BK_READ;
              end
            end
            MODE_LIST: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front_r;
                issued_nxt = CW'(1);
                single_nxt = 1'b0;
                state_nxt  = BK_READ;
              end
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        // Hand the read beat over; fetch the next listed slot if any remain
        if (out_free) begin
          load     = 1'b1;
          ld_value = rd_data_r;
          ld_last  = single_r || (issued_r == count_r);
          if (ld_last) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = ring_add(front_r, issued_r[IW-1:0]);
            issued_nxt = issued_r + 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      issued_r    <= '0;
      single_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      issued_r    <= issued_nxt;
      single_r    <= single_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_value_r  <= ld_value;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  // Slot write and registered slot read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

`default_nettype wire
